/* rtl/ehlm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehlm_pkg
// Shared types and constants for the equal high / equal low matcher.
// ----------------------------------------------------------------------------
package ehlm_pkg;

	// field widths
	localparam int PRICE_W      = 32;
	localparam int BAR_NUM_W    = 32;
	localparam int MATCH_W      = 11;
	localparam int LOOKBACK_W   = 11;
	localparam int TOLERANCE_W  = 4;
	localparam int CFG_DATA_W   = 11;
	localparam int CFG_INDEX_W  = 1;

	// default ring depth
	localparam int HISTORY_DEPTH_DEF = 1024;

	// register reset values
	localparam logic [LOOKBACK_W-1:0]  LOOKBACK_RESET  = 11'd200;
	localparam logic [TOLERANCE_W-1:0] TOLERANCE_RESET = 4'd1;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_LOOKBACK  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = 1'b1;

	// request payloads
	typedef struct packed {
		logic [PRICE_W-1:0] bar_high;
		logic [PRICE_W-1:0] bar_low;
	} in_item_t;

	typedef struct packed {
		logic [BAR_NUM_W-1:0] bar_number;
		logic [MATCH_W-1:0]   high_match_back;
		logic [MATCH_W-1:0]   low_match_back;
	} out_item_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMMIT
	} ehlm_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} ehlm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic search_done;
		logic out_free;
	} ehlm_status_t;

endpackage

/* rtl/ehlm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehlm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ehlm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/ehlm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehlm_datapath
// History rings, backward search walk, configuration registers and the
// output register.
// ----------------------------------------------------------------------------
module ehlm_datapath import ehlm_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ehlm_cmd_t              cmd,
	output ehlm_status_t           status,
	input  in_item_t               in_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data
);

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SW = $clog2(HISTORY_DEPTH + 1);
	localparam int CW = (SW > LOOKBACK_W) ? SW : LOOKBACK_W;
	localparam logic [AW-1:0] LAST_SLOT  = AW'(HISTORY_DEPTH - 1);
	localparam logic [SW-1:0] FULL_COUNT = SW'(HISTORY_DEPTH);

	logic [LOOKBACK_W-1:0]  lookback_q;
	logic [TOLERANCE_W-1:0] tolerance_q;
	logic [AW-1:0]          write_pos_q;
	logic [SW-1:0]          stored_q;
	logic [BAR_NUM_W-1:0]   bar_count_q;

	logic [PRICE_W-1:0]     cur_high_q;
	logic [PRICE_W-1:0]     cur_low_q;
	logic [CW-1:0]          limit_q;
	logic [CW:0]            issue_back_q;
	logic [AW-1:0]          rd_addr_q;
	logic                   cmp_valid_s1;
	logic [CW-1:0]          cmp_back_s1;
	logic                   high_done_q;
	logic                   low_done_q;
	logic [MATCH_W-1:0]     high_back_q;
	logic [MATCH_W-1:0]     low_back_q;

	logic                   out_valid_q;
	out_item_t              out_data_q;

	logic [CW-1:0]          lookback_ext;
	logic [CW-1:0]          stored_ext;
	logic [CW-1:0]          limit_next;
	logic                   issue;
	logic [PRICE_W-1:0]     hist_high;
	logic [PRICE_W-1:0]     hist_low;
	logic                   high_above;
	logic                   low_below;
	logic [PRICE_W-1:0]     high_diff;
	logic [PRICE_W-1:0]     low_diff;
	logic                   high_equal;
	logic                   low_equal;
	logic [AW-1:0]          prev_slot;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookback_q  <= LOOKBACK_RESET;
			tolerance_q <= TOLERANCE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOOKBACK:  lookback_q  <= cfg_data[LOOKBACK_W-1:0];
				CFG_TOLERANCE: tolerance_q <= cfg_data[TOLERANCE_W-1:0];
				default: ;
			endcase
		end
	end

	// search limit: lookback clipped to bars held
	always_comb begin
		lookback_ext = CW'(lookback_q);
		stored_ext   = CW'(stored_q);
		limit_next   = (lookback_ext < stored_ext) ? lookback_ext : stored_ext;
		prev_slot    = (write_pos_q == '0) ? LAST_SLOT : write_pos_q - AW'(1);
	end

	// read issue while bars remain and a walk is still open
	assign issue = cmd.step && ({1'b0, limit_q} >= issue_back_q)
		&& !(high_done_q && low_done_q);

	// history rings
	ehlm_ram #(.WIDTH(PRICE_W), .DEPTH(HISTORY_DEPTH)) u_high_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (write_pos_q),
		.wdata (cur_high_q),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (hist_high)
	);

	ehlm_ram #(.WIDTH(PRICE_W), .DEPTH(HISTORY_DEPTH)) u_low_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (write_pos_q),
		.wdata (cur_low_q),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (hist_low)
	);

	// price compare against tolerance
	always_comb begin
		high_above = hist_high > cur_high_q;
		high_diff  = high_above ? hist_high - cur_high_q : cur_high_q - hist_high;
		high_equal = high_diff <= PRICE_W'(tolerance_q);
		low_below  = hist_low < cur_low_q;
		low_diff   = low_below ? cur_low_q - hist_low : hist_low - cur_low_q;
		low_equal  = low_diff <= PRICE_W'(tolerance_q);
	end

	// search walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_valid_s1 <= 1'b0;
			high_done_q  <= 1'b0;
			low_done_q   <= 1'b0;
			issue_back_q <= '0;
		end else if (cmd.start) begin
			cmp_valid_s1 <= 1'b0;
			high_done_q  <= 1'b0;
			low_done_q   <= 1'b0;
			issue_back_q <= (CW+1)'(1);
		end else begin
			cmp_valid_s1 <= issue;
			if (issue) begin
				issue_back_q <= issue_back_q + (CW+1)'(1);
			end
			if (cmp_valid_s1 && !high_done_q && (high_equal || high_above)) begin
				high_done_q <= 1'b1;
			end
			if (cmp_valid_s1 && !low_done_q && (low_equal || low_below)) begin
				low_done_q <= 1'b1;
			end
		end
	end

	// search walk payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_high_q  <= in_data.bar_high;
			cur_low_q   <= in_data.bar_low;
			limit_q     <= limit_next;
			rd_addr_q   <= prev_slot;
			high_back_q <= '0;
			low_back_q  <= '0;
		end else begin
			if (issue) begin
				cmp_back_s1 <= issue_back_q[CW-1:0];
				rd_addr_q   <= (rd_addr_q == '0) ? LAST_SLOT : rd_addr_q - AW'(1);
			end
			if (cmp_valid_s1 && !high_done_q && high_equal) begin
				high_back_q <= cmp_back_s1[MATCH_W-1:0];
			end
			if (cmp_valid_s1 && !low_done_q && low_equal) begin
				low_back_q <= cmp_back_s1[MATCH_W-1:0];
			end
		end
	end

	// ring position, fill count and bar counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
			stored_q    <= '0;
			bar_count_q <= '0;
		end else if (cmd.commit) begin
			write_pos_q <= (write_pos_q == LAST_SLOT) ? '0 : write_pos_q + AW'(1);
			if (stored_q != FULL_COUNT) begin
				stored_q <= stored_q + SW'(1);
			end
			bar_count_q <= bar_count_q + BAR_NUM_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q.bar_number      <= bar_count_q;
			out_data_q.high_match_back <= high_back_q;
			out_data_q.low_match_back  <= low_back_q;
		end
	end

	// status back to the controller
	assign status.search_done = (high_done_q && low_done_q)
		|| (!cmp_valid_s1 && (issue_back_q > {1'b0, limit_q}));
	assign status.out_free    = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* rtl/ehlm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehlm_ctrl
// Controller: accepts a bar, runs the search walk, then commits the result.
// ----------------------------------------------------------------------------
module ehlm_ctrl import ehlm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  ehlm_status_t status,
	output ehlm_cmd_t    cmd
);

	ehlm_state_t state_q;
	ehlm_state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (status.search_done) begin
					state_next = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cmd.start = in_valid;
			end
			ST_SEARCH: begin
				cmd.step = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = status.out_free;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/equal_high_low_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equal_high_low_matcher
// Finds, for each price bar, the nearest earlier bar with an equal high and
// an equal low within a tick tolerance, over a ring of past bars.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, in_data (in_item_t)  | request in
//  out     | out_valid, out_stall, out_data           | request out
//  cfg     | cfg_we, cfg_index, cfg_data              | write only
//
// A bar is accepted, then walked back over at most limit bars, where limit is
// the lookback clipped to the bars held, one history read per cycle from the
// ring RAMs, pipeline drain, commit. The walk ends early once both matches
// are settled. Reset empties the ring at once through the fill count.
// A finished result sits in the output register; the next bar is accepted
// and searched while it waits, and only its commit waits on out_stall.
// ----------------------------------------------------------------------------
module equal_high_low_matcher import ehlm_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	ehlm_cmd_t    cmd;
	ehlm_status_t status;

	// controller
	ehlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	ehlm_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

/* tb/equal_high_low_matcher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equal_high_low_matcher_tb
// Self-checking bench for the equal high / equal low matcher. Bars go in over
// the request channel. A local copy of the price ring and of the registers
// works out each bar's match distances, and results are checked in order as
// they leave. Both ends idle in random bursts. One stretch holds the output
// back for long enough that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module equal_high_low_matcher_tb;
	import ehlm_pkg::*;

	localparam int DEPTH          = HISTORY_DEPTH_DEF;
	localparam int CLK_HALF       = 5;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int LADDER_BARS    = 300;
	localparam int SWEEP_PHASES   = 10;
	localparam int SWEEP_BARS     = 20;
	localparam int SPARE_W        = CFG_DATA_W - TOLERANCE_W;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	in_item_t               in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_item_t              out_data;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_LOOKBACK;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// local copy of the price ring and the registers
	logic [PRICE_W-1:0]     high_ring [DEPTH];
	logic [PRICE_W-1:0]     low_ring [DEPTH];
	int unsigned            ring_slot = 0;
	int unsigned            ring_fill = 0;
	logic [BAR_NUM_W-1:0]   next_bar_number = '0;
	logic [LOOKBACK_W-1:0]  lookback_reg = LOOKBACK_RESET;
	logic [TOLERANCE_W-1:0] tolerance_reg = TOLERANCE_RESET;

	out_item_t              pending_bars [$];
	int                     error_count = 0;
	int                     idle_cycles = 0;
	bit                     quiet = 1'b0;
	bit                     hold_request = 1'b0;
	logic [PRICE_W-1:0]     price_centre = 32'h0001_0000;

	equal_high_low_matcher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// walk back through the ring for an equal price
	function automatic logic [MATCH_W-1:0] match_distance(input bit is_high,
			input logic [PRICE_W-1:0] price, input int unsigned span);
		logic [PRICE_W-1:0] past;
		logic [PRICE_W-1:0] diff;
		int unsigned slot;
		for (int unsigned back = 1; back <= span; back++) begin
			slot = (ring_slot + DEPTH - back) % DEPTH;
			past = is_high ? high_ring[slot] : low_ring[slot];
			diff = (past > price) ? past - price : price - past;
			if (diff <= PRICE_W'(tolerance_reg))
				return MATCH_W'(back);
			// a higher high or a lower low closes the walk
			if (is_high && past > price)
				return '0;
			if (!is_high && past < price)
				return '0;
		end
		return '0;
	endfunction

	// offer one bar, then predict its result once it is taken
	task automatic send_bar(input logic [PRICE_W-1:0] bar_hi, input logic [PRICE_W-1:0] bar_lo);
		in_item_t bar;
		out_item_t result;
		int unsigned span;
		bar.bar_high = bar_hi;
		bar.bar_low = bar_lo;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= bar;
		do @(posedge clk); while (in_stall);
		span = 32'(lookback_reg);
		if (span > DEPTH)
			span = DEPTH;
		if (span > ring_fill)
			span = ring_fill;
		result.bar_number = next_bar_number;
		result.high_match_back = match_distance(1'b1, bar_hi, span);
		result.low_match_back = match_distance(1'b0, bar_lo, span);
		pending_bars.push_back(result);
		high_ring[ring_slot] = bar_hi;
		low_ring[ring_slot] = bar_lo;
		ring_slot = (ring_slot + 1) % DEPTH;
		if (ring_fill < DEPTH)
			ring_fill++;
		next_bar_number++;
	endtask

	// random bar: mostly prices bunched round a drifting centre
	task automatic send_random_bar();
		logic [PRICE_W-1:0] hi;
		logic [PRICE_W-1:0] lo;
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 2) begin
			hi = $urandom;
			lo = $urandom;
		end else if (pick < 4) begin
			// prices pinned near either end of the range
			hi = PRICE_W'($urandom_range(0, 20));
			lo = PRICE_W'($urandom_range(0, 20));
			if ($urandom_range(0, 1))
				hi = ~hi;
			if ($urandom_range(0, 1))
				lo = ~lo;
		end else begin
			if (pick == 4)
				price_centre = $urandom;
			price_centre = price_centre + PRICE_W'($urandom_range(0, 8)) - 4;
			hi = price_centre + PRICE_W'($urandom_range(0, 20));
			lo = price_centre - PRICE_W'($urandom_range(0, 20));
		end
		send_bar(hi, lo);
	endtask

	// register write, only ever issued while the block is idle
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (reg_index == CFG_LOOKBACK)
			lookback_reg = value;
		else
			tolerance_reg = value[TOLERANCE_W-1:0];
	endtask

	// drop valid and wait for every outstanding result
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_bars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// reset settings, price extremes, zero lookback, tolerance edges
	task automatic test_directed_extremes();
		send_bar(32'hFFFF_FFFF, 32'h0000_0000);
		send_bar(32'hFFFF_FFFF, 32'h0000_0000);
		send_bar(32'hFFFF_FFFE, 32'h0000_0001);
		send_bar(32'h0000_0000, 32'hFFFF_FFFF);
		send_bar(32'd1000, 32'd990);
		send_bar(32'd1003, 32'd987);
		send_bar(32'd1002, 32'd988);
		send_bar(32'd1001, 32'd989);
		wait_idle();
		write_reg(CFG_LOOKBACK, 11'd0);
		send_bar(32'd1002, 32'd988);
		send_bar(32'd1002, 32'd988);
		wait_idle();
		// lookback beyond the ring, tolerance above ten with spare bits set
		write_reg(CFG_LOOKBACK, 11'h7FF);
		write_reg(CFG_TOLERANCE, 11'h7FF);
		send_bar(32'd1017, 32'd973);
		send_bar(32'd1033, 32'd957);
		send_bar(32'd1049, 32'd941);
		wait_idle();
		write_reg(CFG_TOLERANCE, 11'h7F0);
		send_bar(32'd1049, 32'd941);
		send_bar(32'd1050, 32'd940);
		wait_idle();
		write_reg(CFG_LOOKBACK, 11'd1);
		send_bar(32'd1049, 32'd941);
		send_bar(32'd1050, 32'd940);
		send_bar(32'd1050, 32'd940);
		wait_idle();
	endtask

	// long ladder, then walks across every bar held
	task automatic test_long_walk();
		logic [PRICE_W-1:0] top;
		logic [PRICE_W-1:0] floor_price;
		top = 32'hC000_0000;
		floor_price = 32'h1000_0000;
		write_reg(CFG_LOOKBACK, 11'd4);
		write_reg(CFG_TOLERANCE, 11'd0);
		// falling highs and rising lows, each price used once
		for (int i = 0; i < LADDER_BARS; i++)
			send_bar(top - PRICE_W'(4 * i), floor_price + PRICE_W'(4 * i));
		wait_idle();
		// first bar of the ladder matches at the far end of the ladder
		write_reg(CFG_LOOKBACK, LOOKBACK_W'(DEPTH));
		send_bar(top, floor_price);
		wait_idle();
		// just outside every ladder price: walk through the ladder with no match
		write_reg(CFG_LOOKBACK, 11'h7FF);
		send_bar(top + 32'd4, floor_price - 32'd4);
		wait_idle();
	endtask

	// random bars over a run of register settings
	task automatic test_random_sweep();
		logic [LOOKBACK_W-1:0] lookbacks [SWEEP_PHASES];
		logic [TOLERANCE_W-1:0] tolerances [SWEEP_PHASES];
		lookbacks = '{11'd1, 11'd2047, 11'd1024, 11'd2, 11'd37,
			11'd200, 11'd511, 11'd1023, 11'd0, 11'd0};
		tolerances = '{4'd0, 4'd15, 4'd10, 4'd1, 4'd3, 4'd7, 4'd0, 4'd12, 4'd0, 4'd0};
		for (int p = SWEEP_PHASES - 2; p < SWEEP_PHASES; p++) begin
			lookbacks[p] = LOOKBACK_W'($urandom_range(0, 2047));
			tolerances[p] = TOLERANCE_W'($urandom_range(0, 15));
		end
		for (int p = 0; p < SWEEP_PHASES; p++) begin
			write_reg(CFG_LOOKBACK, lookbacks[p]);
			write_reg(CFG_TOLERANCE, {SPARE_W'($urandom), tolerances[p]});
			repeat (SWEEP_BARS) send_random_bar();
			wait_idle();
		end
	endtask

	// receiver holds off for a long stretch while bars keep coming
	task automatic test_backpressure();
		hold_request = 1'b1;
		repeat (12) send_random_bar();
		wait_idle();
	endtask

	// last stretch with neither side idling
	task automatic test_quiet_tail();
		quiet = 1'b1;
		write_reg(CFG_LOOKBACK, 11'd300);
		write_reg(CFG_TOLERANCE, 11'd2);
		repeat (48) send_random_bar();
	endtask

	// receiver stalls: random bursts, or one long hold on request
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each result leaving the block with the oldest prediction
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bars.size() == 0) begin
				$error("unexpected result for bar_number %0d", out_data.bar_number);
				error_count++;
			end else begin
				want = pending_bars.pop_front();
				if (out_data.bar_number !== want.bar_number) begin
					$error("bar_number: expected %0d, got %0d",
						want.bar_number, out_data.bar_number);
					error_count++;
				end
				if (out_data.high_match_back !== want.high_match_back) begin
					$error("high_match_back: expected %0d, got %0d",
						want.high_match_back, out_data.high_match_back);
					error_count++;
				end
				if (out_data.low_match_back !== want.low_match_back) begin
					$error("low_match_back: expected %0d, got %0d",
						want.low_match_back, out_data.low_match_back);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no request moving either way
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** equal_high_low_matcher: FAILED **");
			$finish;
		end
	end

	// test sequence
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_long_walk();
		test_random_sweep();
		test_backpressure();
		test_quiet_tail();
		wait_idle();
		if (error_count == 0)
			$display("** equal_high_low_matcher: PASSED **");
		else
			$display("** equal_high_low_matcher: FAILED **");
		$finish;
	end

endmodule
